// ===== hdl/alt_pkg.sv =====
// alt_pkg: word types, result kinds and character codes for the assembly line tokenizer
// no dependencies; imported by alt_step, alt_res_queue and assembly_line_tokenizer_core
package alt_pkg;

	localparam int SYM_W   = 8;
	localparam int KIND_W  = 2;
	localparam int START_W = 12;
	localparam int LEN_W   = 13;
	localparam int NUM_W   = 9;

	localparam logic [KIND_W-1:0] KIND_WORD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STRING  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BRACKET = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd3;

	localparam logic [SYM_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [SYM_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [SYM_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [SYM_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [SYM_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [SYM_W-1:0] CH_TAB    = 8'h09;
	localparam logic [SYM_W-1:0] CH_CR     = 8'h0D;

	// result queue depth, room for two results per step
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             line_end;
	} char_word_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [START_W-1:0] token_start;
		logic [LEN_W-1:0]   token_length;
		logic [NUM_W-1:0]   token_number;
		logic               unclosed_string;
		logic               too_many_tokens;
		logic               last;
	} tok_word_t;

	// results of one step: count and up to two words in order
	typedef struct packed {
		logic [1:0] n;
		tok_word_t  r0;
		tok_word_t  r1;
	} step_out_t;

	// space, tab, line feed, vertical tab, form feed, return
	function automatic logic is_blank(input logic [SYM_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ===== hdl/alt_step.sv =====
// alt_step: line state registers and the per-character tokenizing step
// depends on alt_pkg
module alt_step import alt_pkg::*; #(
	parameter int MAX_TOKENS = 256,
	parameter int LINE_CHARS = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  char_word_t item,
	output step_out_t  res
);

	localparam int PW = $clog2(LINE_CHARS + 1);
	localparam int TW = $clog2(MAX_TOKENS + 1);
	localparam logic [PW-1:0] LINE_LIM = PW'(LINE_CHARS);
	localparam logic [TW-1:0] TOK_LIM  = TW'(MAX_TOKENS);

	logic          in_word_q, in_string_q, overflow_q;
	logic [PW-1:0] position_q, start_q;
	logic [TW-1:0] total_q;

	logic          in_word_d, in_string_d, overflow_d;
	logic [PW-1:0] position_d, start_d;
	logic [TW-1:0] total_d;

	logic            a_v, b_v, ea, eb;
	tok_word_t       a, b;
	logic [TW-1:0]   total1;
	logic [PW-1:0]   diff;
	logic [LEN_W-1:0] word_len, str_len;

	always_comb begin
		diff     = position_q - start_q;
		word_len = LEN_W'(diff);
		str_len  = LEN_W'({1'b0, diff} + {{PW{1'b0}}, 1'b1});

		a = '0;
		b = '0;
		a_v = 1'b0;
		b_v = 1'b0;
		a.kind         = KIND_WORD;
		a.token_start  = START_W'(start_q);
		a.token_length = word_len;
		b.kind         = KIND_BRACKET;
		b.token_start  = START_W'(position_q);
		b.token_length = LEN_W'(1);

		in_word_d   = in_word_q;
		in_string_d = in_string_q;
		position_d  = position_q;
		start_d     = start_q;

		priority if (item.line_end) begin
			a_v = in_word_q;
			b_v = 1'b1;
			b.kind         = KIND_SUMMARY;
			b.token_start  = '0;
			b.token_length = '0;
		end else if (position_q != LINE_LIM) begin
			position_d = position_q + 1'b1;
			priority if (item.symbol == CH_QUOTE) begin
				if (in_string_q) begin
					a_v = 1'b1;
					a.kind         = KIND_STRING;
					a.token_length = str_len;
					in_string_d    = 1'b0;
				end else begin
					a_v         = in_word_q;
					in_word_d   = 1'b0;
					in_string_d = 1'b1;
					start_d     = position_q;
				end
			end else if (is_blank(item.symbol) || item.symbol == CH_COMMA) begin
				a_v       = in_word_q;
				in_word_d = 1'b0;
			end else if (!in_string_q) begin
				if (item.symbol == CH_LBRACK || item.symbol == CH_RBRACK) begin
					a_v       = in_word_q;
					b_v       = 1'b1;
					in_word_d = 1'b0;
				end else if (!in_word_q) begin
					in_word_d = 1'b1;
					start_d   = position_q;
				end
			end else begin
				// plain character inside a string, nothing to do
			end
		end else begin
			// line is full, the character is ignored
		end

		// token limit, tokens beyond it are dropped
		ea     = a_v && (total_q != TOK_LIM);
		total1 = total_q + TW'(ea);
		eb     = b_v && (item.line_end || (total1 != TOK_LIM));
		total_d    = total1 + TW'(eb && !item.line_end);
		overflow_d = overflow_q || (a_v && !ea) || (b_v && !eb);

		a.token_number = NUM_W'(total_q);
		b.token_number = NUM_W'(total1);
		if (item.line_end) begin
			b.unclosed_string = in_string_q;
			b.too_many_tokens = overflow_d;
		end

		res.n  = {1'b0, ea} + {1'b0, eb};
		res.r0 = ea ? a : b;
		res.r1 = b;
		res.r0.last = (res.n == 2'd1);
		res.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q   <= 1'b0;
			in_string_q <= 1'b0;
			overflow_q  <= 1'b0;
			position_q  <= '0;
			start_q     <= '0;
			total_q     <= '0;
		end else if (go) begin
			if (item.line_end) begin
				in_word_q   <= 1'b0;
				in_string_q <= 1'b0;
				overflow_q  <= 1'b0;
				position_q  <= '0;
				start_q     <= '0;
				total_q     <= '0;
			end else begin
				in_word_q   <= in_word_d;
				in_string_q <= in_string_d;
				overflow_q  <= overflow_d;
				position_q  <= position_d;
				start_q     <= start_d;
				total_q     <= total_d;
			end
		end
	end

endmodule

// ===== hdl/alt_res_queue.sv =====
// alt_res_queue: small result queue, takes up to two words a cycle, gives one while tok_stall is low
// depends on alt_pkg
module alt_res_queue import alt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  step_out_t res,
	output logic      room,
	output logic      tok_valid,
	input  logic      tok_stall,
	output tok_word_t tok_word
);

	tok_word_t      mem [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] count_q;
	logic [1:0]     n;
	logic           pop;

	assign n         = push ? res.n : 2'd0;
	assign tok_valid = (count_q != '0);
	assign pop       = tok_valid && !tok_stall;
	assign room      = (count_q <= QCW'(QDEPTH - 2));
	assign tok_word  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (n != 2'd0) begin
			mem[wr_q] <= res.r0;
		end
		if (n == 2'd2) begin
			mem[wr_q + 1'b1] <= res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QAW'(n);
			rd_q    <= rd_q + QAW'(pop);
			count_q <= count_q + QCW'(n) - QCW'(pop);
		end
	end

endmodule

// ===== hdl/assembly_line_tokenizer_core.sv =====
// assembly_line_tokenizer_core: top level of the assembly line tokenizer
// depends on alt_pkg, alt_step and alt_res_queue
//
// usage
//   char channel: one word per character (symbol), or a word with line_end set
//     that closes the line; accepted when char_valid is high and char_stall low
//   tok channel: token words (word, quoted string, bracket) and one line summary
//     per line_end; given when tok_valid is high, taken when tok_stall is low;
//     last marks the final result of one character word
//   path: an accepted character waits in the input register and is tokenized
//     once the queue has room; its results go into the queue, then onto tok_word
//   throughput: one character per cycle while char_stall is low; results leave
//     at one per cycle while tok_stall is low, so a character that gives two
//     results (word closed by a bracket or by the line end) takes two reads on
//     the tok side, set by the single read port of the four-entry result queue
//   reset: arst_n clears the line state, the input valid flag and the queue
//   stall: while tok_stall is high the queue fills; once it cannot take two
//     more results, the input register holds and char_stall rises
module assembly_line_tokenizer_core import alt_pkg::*; #(
	parameter int MAX_TOKENS = 256,
	parameter int LINE_CHARS = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_word_t char_word,
	output logic       tok_valid,
	input  logic       tok_stall,
	output tok_word_t  tok_word
);

	// input register
	logic       valid_s1;
	char_word_t word_s1;

	logic      room, take;
	step_out_t res;

	// the input register drains when the queue has room for two results
	assign take       = valid_s1 && room;
	assign char_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload holds no reset
	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			word_s1 <= char_word;
		end
	end

	// line state and token decisions
	alt_step #(
		.MAX_TOKENS(MAX_TOKENS),
		.LINE_CHARS(LINE_CHARS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (take),
		.item   (word_s1),
		.res    (res)
	);

	// results wait here for the receiver
	alt_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.res       (res),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_word  (tok_word)
	);

endmodule
